### rtl/bth_pkg.sv
// Shared constants, types and helpers for the boundary-tag heap allocator.
`timescale 1ns / 1ps
package bth_pkg;

    // Heap geometry
    localparam int unsigned HEAP_BYTES   = 1048576;
    localparam int unsigned ADDR_W       = 20;
    localparam int unsigned SIZE_W       = ADDR_W + 1;
    localparam int unsigned WORD_AW      = ADDR_W - 3;
    localparam int unsigned HEAP_WORDS   = HEAP_BYTES / 8;
    localparam int unsigned DATA_W       = 64;
    localparam int unsigned MIN_CHUNK    = 48;
    localparam int unsigned USABLE_BYTES = HEAP_BYTES - 16;
    localparam int unsigned MAX_REQ      = USABLE_BYTES - 16;
    localparam int unsigned WALK_LIMIT   = HEAP_BYTES / MIN_CHUNK + 1;
    localparam int unsigned STEP_W       = $clog2(WALK_LIMIT + 1);
    localparam int unsigned REQ_W        = 21;

    // Opcodes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_INIT    = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_BADSIZE = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;

    // One access to the heap memory
    typedef struct packed {
        logic               en;
        logic               we;
        logic [WORD_AW-1:0] addr;
        logic [DATA_W-1:0]  wdata;
    } mem_req_t;

    // Word index of a byte address
    function automatic logic [WORD_AW-1:0] widx(input logic [ADDR_W-1:0] a);
        return a[ADDR_W-1:3];
    endfunction

endpackage

### rtl/bth_ram.sv
// Single-port heap word memory with registered read data.
`timescale 1ns / 1ps
module bth_ram
    import bth_pkg::*;
(
    input  logic              aclk,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [HEAP_WORDS];

    // one access per cycle: write, or read into the output register
    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) begin
                mem[req.addr] <= req.wdata;
            end else begin
                rdata <= mem[req.addr];
            end
        end
    end

endmodule

### rtl/bth_seq.sv
// Allocator sequencer: clear pass, first-fit walk, split, coalesce, list edits.
`timescale 1ns / 1ps
module bth_seq
    import bth_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_opcode,
    input  logic [REQ_W-1:0]  in_req,
    input  logic [ADDR_W-1:0] in_off,
    input  logic              res_ready,
    output logic              res_done,
    output logic [ADDR_W-1:0] res_off,
    output logic [1:0]        res_status,
    output mem_req_t          mreq,
    input  logic [DATA_W-1:0] mrdata
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CLR   = 5'd1;
    localparam logic [4:0] S_INIT1 = 5'd2;
    localparam logic [4:0] S_INIT2 = 5'd3;
    localparam logic [4:0] S_FIN   = 5'd4;
    localparam logic [4:0] S_A_CHK = 5'd5;
    localparam logic [4:0] S_A_SZ  = 5'd6;
    localparam logic [4:0] S_A_NX  = 5'd7;
    localparam logic [4:0] S_A_SPL = 5'd8;
    localparam logic [4:0] S_A_S2  = 5'd9;
    localparam logic [4:0] S_A_S3  = 5'd10;
    localparam logic [4:0] S_R_SZ  = 5'd11;
    localparam logic [4:0] S_R_P0  = 5'd12;
    localparam logic [4:0] S_R_P1  = 5'd13;
    localparam logic [4:0] S_R_N0  = 5'd14;
    localparam logic [4:0] S_R_N1  = 5'd15;
    localparam logic [4:0] S_R_T   = 5'd16;
    localparam logic [4:0] S_R_L   = 5'd17;
    localparam logic [4:0] S_U0    = 5'd18;
    localparam logic [4:0] S_U1    = 5'd19;
    localparam logic [4:0] S_U2    = 5'd20;
    localparam logic [4:0] S_U3    = 5'd21;
    localparam logic [4:0] S_U4    = 5'd22;
    localparam logic [4:0] S_T0    = 5'd23;
    localparam logic [4:0] S_T1    = 5'd24;
    localparam logic [4:0] S_L0    = 5'd25;
    localparam logic [4:0] S_L1    = 5'd26;
    localparam logic [4:0] S_L2    = 5'd27;

    localparam logic [ADDR_W-1:0] OFF8  = ADDR_W'(8);
    localparam logic [ADDR_W-1:0] OFF16 = ADDR_W'(16);

    logic [4:0]         state_reg, state_next, ret_reg, ret_next;
    logic [ADDR_W-1:0]  fit_reg, fit_next;      // block under work
    logic [SIZE_W-1:0]  size_reg, size_next;
    logic [SIZE_W-1:0]  need_reg, need_next;
    logic [SIZE_W-1:0]  have_reg, have_next;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [ADDR_W-1:0]  p_reg, p_next, n_reg, n_next, u_reg, u_next;
    logic [ADDR_W-1:0]  ta_reg, ta_next, la_reg, la_next;
    logic [SIZE_W-1:0]  ts_reg, ts_next;
    logic               tu_reg, tu_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [WORD_AW-1:0] cnt_reg, cnt_next;
    logic               reply_reg, reply_next;
    logic [ADDR_W-1:0]  roff_reg, roff_next;
    logic [1:0]         rst_reg, rst_next;

    logic [REQ_W+1:0]   need_raw;
    logic [SIZE_W-1:0]  need_rnd, rd_size, nb;
    logic [DATA_W-1:0]  tag_val;

    assign need_raw = {2'b00, in_req} + (REQ_W+2)'(31);
    assign need_rnd = {need_raw[SIZE_W-1:4], 4'b0000};
    assign rd_size  = {mrdata[SIZE_W-1:4], 4'b0000};
    assign nb       = {1'b0, fit_reg} + size_reg;
    assign tag_val  = {{(DATA_W-SIZE_W){1'b0}}, ts_reg[SIZE_W-1:4], 3'b000, tu_reg};

    assign in_ready   = (state_reg == S_IDLE);
    assign res_done   = (state_reg == S_FIN) && res_ready;
    assign res_off    = roff_reg;
    assign res_status = rst_reg;

    // sequencer next state and memory request
    always_comb begin
        state_next = state_reg;  ret_next   = ret_reg;   fit_next  = fit_reg;
        size_next  = size_reg;   need_next  = need_reg;  have_next = have_reg;
        head_next  = head_reg;   p_next     = p_reg;     n_next    = n_reg;
        u_next     = u_reg;      ta_next    = ta_reg;    la_next   = la_reg;
        ts_next    = ts_reg;     tu_next    = tu_reg;    steps_next = steps_reg;
        cnt_next   = cnt_reg;    reply_next = reply_reg; roff_next = roff_reg;
        rst_next   = rst_reg;
        mreq       = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    reply_next = 1'b1;
                    roff_next  = '0;
                    rst_next   = ST_DONE;
                    priority if (in_opcode == OP_ALLOC) begin
                        if (in_req == '0 || in_req > REQ_W'(MAX_REQ)) begin
                            rst_next   = ST_BADSIZE;
                            state_next = S_FIN;
                        end else begin
                            need_next  = (need_rnd < SIZE_W'(MIN_CHUNK)) ?
                                         SIZE_W'(MIN_CHUNK) : need_rnd;
                            fit_next   = head_reg;
                            steps_next = '0;
                            state_next = S_A_CHK;
                        end
                    end else if (in_opcode == OP_RELEASE) begin
                        if (in_off == '0) begin
                            state_next = S_FIN;
                        end else begin
                            fit_next   = in_off - OFF8;
                            mreq.en    = 1'b1;
                            mreq.addr  = widx(in_off - OFF8);
                            state_next = S_R_SZ;
                        end
                    end else if (in_opcode == OP_INIT) begin
                        cnt_next   = '0;
                        state_next = S_CLR;
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            // zero the whole heap, one word a cycle
            S_CLR: begin
                mreq.en   = 1'b1;
                mreq.we   = 1'b1;
                mreq.addr = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == WORD_AW'(HEAP_WORDS - 1)) state_next = S_INIT1;
            end
            S_INIT1: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = widx(OFF8);
                mreq.wdata = DATA_W'(USABLE_BYTES);
                state_next = S_INIT2;
            end
            S_INIT2: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = widx(ADDR_W'(USABLE_BYTES));
                mreq.wdata = DATA_W'(USABLE_BYTES);
                head_next  = OFF8;
                state_next = reply_reg ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (res_ready) begin
                    reply_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            // first-fit walk
            S_A_CHK: begin
                if (fit_reg == '0) begin
                    rst_next   = ST_NOFIT;
                    state_next = S_FIN;
                end else begin
                    mreq.en    = 1'b1;
                    mreq.addr  = widx(fit_reg);
                    state_next = S_A_SZ;
                end
            end
            S_A_SZ: begin
                if (rd_size >= need_reg) begin
                    have_next  = rd_size;
                    u_next     = fit_reg;
                    ret_next   = S_A_SPL;
                    state_next = S_U0;
                end else if (steps_reg + 1'b1 >= STEP_W'(WALK_LIMIT)) begin
                    rst_next   = ST_NOFIT;
                    state_next = S_FIN;
                end else begin
                    steps_next = steps_reg + 1'b1;
                    mreq.en    = 1'b1;
                    mreq.addr  = widx(fit_reg + OFF16);
                    state_next = S_A_NX;
                end
            end
            S_A_NX: begin
                fit_next   = mrdata[ADDR_W-1:0];
                state_next = S_A_CHK;
            end
            // split or take whole
            S_A_SPL: begin
                roff_next  = fit_reg + OFF8;
                ta_next    = fit_reg;
                tu_next    = 1'b1;
                state_next = S_T0;
                if (have_reg - need_reg >= SIZE_W'(MIN_CHUNK)) begin
                    ts_next  = need_reg;
                    ret_next = S_A_S2;
                end else begin
                    ts_next  = have_reg;
                    ret_next = S_FIN;
                end
            end
            S_A_S2: begin
                ta_next    = fit_reg + need_reg[ADDR_W-1:0];
                ts_next    = have_reg - need_reg;
                tu_next    = 1'b0;
                ret_next   = S_A_S3;
                state_next = S_T0;
            end
            S_A_S3: begin
                la_next    = fit_reg + need_reg[ADDR_W-1:0];
                ret_next   = S_FIN;
                state_next = S_L0;
            end
            // release: free the block, then merge with neighbors
            S_R_SZ: begin
                size_next  = rd_size;
                ta_next    = fit_reg;
                ts_next    = rd_size;
                tu_next    = 1'b0;
                ret_next   = S_R_P0;
                state_next = S_T0;
            end
            S_R_P0: begin
                if (fit_reg > OFF8) begin
                    mreq.en    = 1'b1;
                    mreq.addr  = widx(fit_reg - OFF8);
                    state_next = S_R_P1;
                end else begin
                    state_next = S_R_N0;
                end
            end
            S_R_P1: begin
                if (!mrdata[0]) begin
                    fit_next   = fit_reg - rd_size[ADDR_W-1:0];
                    u_next     = fit_reg - rd_size[ADDR_W-1:0];
                    size_next  = size_reg + rd_size;
                    ret_next   = S_R_N0;
                    state_next = S_U0;
                end else begin
                    state_next = S_R_N0;
                end
            end
            S_R_N0: begin
                if (nb < SIZE_W'(HEAP_BYTES - 8)) begin
                    mreq.en    = 1'b1;
                    mreq.addr  = widx(nb[ADDR_W-1:0]);
                    state_next = S_R_N1;
                end else begin
                    state_next = S_R_T;
                end
            end
            S_R_N1: begin
                if (!mrdata[0]) begin
                    size_next  = size_reg + rd_size;
                    u_next     = nb[ADDR_W-1:0];
                    ret_next   = S_R_T;
                    state_next = S_U0;
                end else begin
                    state_next = S_R_T;
                end
            end
            S_R_T: begin
                ta_next    = fit_reg;
                ts_next    = size_reg;
                tu_next    = 1'b0;
                ret_next   = S_R_L;
                state_next = S_T0;
            end
            S_R_L: begin
                la_next    = fit_reg;
                ret_next   = S_FIN;
                state_next = S_L0;
            end
            // unlink u from the free list
            S_U0: begin
                mreq.en    = 1'b1;
                mreq.addr  = widx(u_reg + OFF8);
                state_next = S_U1;
            end
            S_U1: begin
                p_next     = mrdata[ADDR_W-1:0];
                mreq.en    = 1'b1;
                mreq.addr  = widx(u_reg + OFF16);
                state_next = S_U2;
            end
            S_U2: begin
                n_next = mrdata[ADDR_W-1:0];
                if (p_reg != '0) begin
                    state_next = S_U3;
                end else begin
                    head_next  = mrdata[ADDR_W-1:0];
                    state_next = S_U4;
                end
            end
            S_U3: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = widx(p_reg + OFF16);
                mreq.wdata = {{(DATA_W-ADDR_W){1'b0}}, n_reg};
                state_next = S_U4;
            end
            S_U4: begin
                mreq.en    = (n_reg != '0);
                mreq.we    = 1'b1;
                mreq.addr  = widx(n_reg + OFF8);
                mreq.wdata = {{(DATA_W-ADDR_W){1'b0}}, p_reg};
                state_next = ret_reg;
            end
            // header and footer tags
            S_T0: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = widx(ta_reg);
                mreq.wdata = tag_val;
                state_next = S_T1;
            end
            S_T1: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = widx(ta_reg + ts_reg[ADDR_W-1:0] - OFF8);
                mreq.wdata = tag_val;
                state_next = ret_reg;
            end
            // push la at the list head
            S_L0: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = widx(la_reg + OFF8);
                state_next = S_L1;
            end
            S_L1: begin
                mreq.en    = 1'b1;
                mreq.we    = 1'b1;
                mreq.addr  = widx(la_reg + OFF16);
                mreq.wdata = {{(DATA_W-ADDR_W){1'b0}}, head_reg};
                state_next = S_L2;
            end
            S_L2: begin
                mreq.en    = (head_reg != '0);
                mreq.we    = 1'b1;
                mreq.addr  = widx(head_reg + OFF8);
                mreq.wdata = {{(DATA_W-ADDR_W){1'b0}}, la_reg};
                head_next  = la_reg;
                state_next = ret_reg;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
            reply_reg <= 1'b0;
            head_reg  <= OFF8;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            reply_reg <= reply_next;
            head_reg  <= head_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        ret_reg   <= ret_next;   fit_reg  <= fit_next;  size_reg  <= size_next;
        need_reg  <= need_next;  have_reg <= have_next; p_reg     <= p_next;
        n_reg     <= n_next;     u_reg    <= u_next;    ta_reg    <= ta_next;
        la_reg    <= la_next;    ts_reg   <= ts_next;   tu_reg    <= tu_next;
        steps_reg <= steps_next; roff_reg <= roff_next; rst_reg   <= rst_next;
    end

    // a result leaves only from the finish state, and the sequencer then idles
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_done |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after a result");

    // no item is taken while the heap is being cleared
    a_clr_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLR |-> !in_ready)
        else $error("item accepted during clear pass");

    // memory is quiet while the result waits to be taken
    a_quiet_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIN |-> !mreq.en)
        else $error("memory access while holding a result");

endmodule

### rtl/boundary_tag_heap_allocator.sv
// Top level: heap memory, allocator sequencer and result register.
// Allocate: time grows with a split and with each free block passed by the first-fit walk.
// Release: time set by merges and the single memory port (one access a cycle). Bad size,
// null release and unused opcode go straight to the result. One item is in work at a time,
// and the next is taken while the result register waits. Reset and re-initialize run a clear
// pass of all 131072 words and 2 tag writes, no item accepted; list head returns to offset 8.
`timescale 1ns / 1ps
module boundary_tag_heap_allocator
    import bth_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [REQ_W-1:0]  s_request_bytes,
    input  logic [ADDR_W-1:0] s_payload_offset,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ADDR_W-1:0] m_granted_offset,
    output logic [1:0]        m_status
);

    mem_req_t          mreq;
    logic [DATA_W-1:0] mrdata;
    logic              res_ready, res_done;
    logic [ADDR_W-1:0] res_off;
    logic [1:0]        res_status;
    logic              m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0] m_off_reg;
    logic [1:0]        m_st_reg;

    bth_ram u_ram (
        .aclk  (aclk),
        .req   (mreq),
        .rdata (mrdata)
    );

    bth_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_opcode  (s_opcode),
        .in_req     (s_request_bytes),
        .in_off     (s_payload_offset),
        .res_ready  (res_ready),
        .res_done   (res_done),
        .res_off    (res_off),
        .res_status (res_status),
        .mreq       (mreq),
        .mrdata     (mrdata)
    );

    // result register
    assign res_ready    = !m_valid_reg || m_ready;
    assign m_valid_next = res_done || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_done) begin
            m_off_reg <= res_off;
            m_st_reg  <= res_status;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_granted_offset = m_off_reg;
    assign m_status         = m_st_reg;

endmodule

### bench/boundary_tag_heap_allocator_tb.sv
// Testbench for the boundary-tag heap allocator: self-checking, with its own heap predictor.
`timescale 1ns / 1ps
module boundary_tag_heap_allocator_tb
    import bth_pkg::*;
();

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [1:0]        status;
    } grant_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_opcode;
    logic [REQ_W-1:0]  s_request_bytes;
    logic [ADDR_W-1:0] s_payload_offset;
    logic              m_valid;
    logic              m_ready;
    logic [ADDR_W-1:0] m_granted_offset;
    logic [1:0]        m_status;

    boundary_tag_heap_allocator dut (.*);

    // predictor state: sparse heap image and free-list head
    logic [63:0]       heap_img [int unsigned];
    longint unsigned   list_top;
    grant_t            grant_q[$];
    int unsigned       live_blocks[$];
    int unsigned       error_count;
    int unsigned       cycle_count = 0;
    bit                gaps_on;
    bit                hold_sink;

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // runaway guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("boundary_tag_heap_allocator verification failed");
            $finish;
        end
    end

    function automatic longint unsigned heap_rd(longint unsigned a);
        int unsigned w;
        w = int'((a % HEAP_BYTES) >> 3);
        return heap_img.exists(w) ? heap_img[w] : 64'd0;
    endfunction

    function automatic void heap_wr(longint unsigned a, longint unsigned v);
        heap_img[int'((a % HEAP_BYTES) >> 3)] = v;
    endfunction

    function automatic longint unsigned blk_bytes(longint unsigned b);
        return heap_rd(b) & ~64'hf;
    endfunction

    function automatic void put_tags(longint unsigned b, longint unsigned sz, bit used);
        heap_wr(b, sz | used);
        heap_wr(b + sz - 8, sz | used);
    endfunction

    function automatic void list_remove(longint unsigned b);
        longint unsigned p, n;
        p = heap_rd(b + 8);
        n = heap_rd(b + 16);
        if (p != 0) heap_wr(p + 16, n);
        else list_top = n;
        if (n != 0) heap_wr(n + 8, p);
    endfunction

    function automatic void list_push(longint unsigned b);
        heap_wr(b + 8, 0);
        heap_wr(b + 16, list_top);
        if (list_top != 0) heap_wr(list_top + 8, b);
        list_top = b;
    endfunction

    function automatic void heap_fresh();
        heap_img.delete();
        list_top = 8;
        put_tags(8, USABLE_BYTES, 1'b0);
    endfunction

    // first-fit allocate
    function automatic grant_t predict_alloc(longint unsigned req);
        grant_t          g;
        longint unsigned need, fit, have, steps;
        g = '0;
        steps = 0;
        if (req == 0 || req > MAX_REQ) begin
            g.status = ST_BADSIZE;
            return g;
        end
        need = (req + 31) & ~64'hf;
        if (need < MIN_CHUNK) need = MIN_CHUNK;
        fit = list_top;
        while (fit != 0 && blk_bytes(fit) < need) begin
            steps++;
            if (steps >= WALK_LIMIT) begin
                fit = 0;
                break;
            end
            fit = heap_rd(fit + 16);
        end
        if (fit == 0) begin
            g.status = ST_NOFIT;
            return g;
        end
        have = blk_bytes(fit);
        list_remove(fit);
        if (have - need >= MIN_CHUNK) begin
            put_tags(fit, need, 1'b1);
            put_tags(fit + need, have - need, 1'b0);
            list_push((fit + need) % HEAP_BYTES);
        end else begin
            put_tags(fit, have, 1'b1);
        end
        g.offset = ADDR_W'(fit + 8);
        g.status = ST_DONE;
        return g;
    endfunction

    // release with merge on both sides
    function automatic void predict_release(longint unsigned pay);
        longint unsigned b, sz, ptag, psz, prv, nxt, ntag;
        if (pay == 0) return;
        b = (pay % HEAP_BYTES + HEAP_BYTES - 8) % HEAP_BYTES;
        sz = blk_bytes(b);
        put_tags(b, sz, 1'b0);
        if (b > 8) begin
            ptag = heap_rd(b - 8);
            if (ptag[0] == 1'b0) begin
                psz = ptag & ~64'hf;
                prv = (b - psz) % HEAP_BYTES;
                list_remove(prv);
                b = prv;
                sz += psz;
            end
        end
        nxt = b + sz;
        if (nxt < 8 + USABLE_BYTES) begin
            ntag = heap_rd(nxt);
            if (ntag[0] == 1'b0) begin
                sz += blk_bytes(nxt);
                list_remove(nxt);
            end
        end
        put_tags(b, sz, 1'b0);
        list_push(b);
    endfunction

    // send one item and queue its expected result
    task automatic send_item(logic [1:0] op, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] off);
        int unsigned gap;
        grant_t      g;
        gap = gaps_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_opcode         <= op;
        s_request_bytes  <= req;
        s_payload_offset <= off;
        do @(posedge aclk); while (!s_ready);
        g = '0;
        case (op)
            OP_ALLOC: begin
                g = predict_alloc(req);
                if (g.status == ST_DONE) live_blocks.push_back(g.offset);
            end
            OP_RELEASE: predict_release(off);
            OP_INIT: begin
                heap_fresh();
                live_blocks.delete();
            end
            default: ;
        endcase
        grant_q.push_back(g);
    endtask

    task automatic free_live(int unsigned idx);
        int unsigned off;
        off = live_blocks[idx];
        live_blocks.delete(idx);
        send_item(OP_RELEASE, '0, ADDR_W'(off));
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] %s mismatch: got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // result sink with random stalls and an optional long hold-off
    initial begin
        grant_t      want;
        int unsigned stall;
        bit          holding;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            holding = hold_sink;
            stall = holding ? HOLD_CYCLES : (gaps_on ? $urandom_range(0, 6) : 0);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                if (holding) hold_sink = 1'b0;
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (grant_q.size() == 0) begin
                report_mismatch("unexpected item, status", m_status, 0);
            end else begin
                want = grant_q.pop_front();
                if (m_granted_offset !== want.offset)
                    report_mismatch("granted_offset", m_granted_offset, want.offset);
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
            end
        end
    end

    // extremes, every opcode, exact fit, no split, null release, unused opcode
    task automatic test_directed();
        send_item(OP_ALLOC, '0, '0);
        send_item(OP_ALLOC, REQ_W'(MAX_REQ + 1), '0);
        send_item(OP_ALLOC, '1, '0);
        send_item(OP_ALLOC, REQ_W'(MAX_REQ), '0);
        send_item(OP_ALLOC, REQ_W'(1), '0);
        free_live(0);
        send_item(OP_ALLOC, REQ_W'(MAX_REQ - 48), '0);
        free_live(0);
        send_item(OP_ALLOC, REQ_W'(1), '0);
        send_item(OP_ALLOC, REQ_W'(32), '0);
        send_item(OP_ALLOC, REQ_W'(33), '0);
        send_item(OP_ALLOC, REQ_W'(600000), '0);
        send_item(OP_ALLOC, REQ_W'(400000), '0);
        send_item(OP_RELEASE, '0, '0);
        send_item(OP_UNUSED, '1, '1);
        free_live(1);
        free_live(0);
        free_live(0);
        free_live(0);
        free_live(0);
        send_item(OP_ALLOC, REQ_W'(100), '0);
        send_item(OP_INIT, '0, '0);
        send_item(OP_ALLOC, REQ_W'(5000), '0);
    endtask

    // mostly alloc/free traffic of small blocks, with rare large and bad sizes
    task automatic test_random(int unsigned count, bit with_hold);
        int unsigned pick;
        logic [REQ_W-1:0] req;
        for (int unsigned i = 0; i < count; i++) begin
            gaps_on = ((i / 100) % 4) != 3;
            if (with_hold && i == count / 2) hold_sink = 1'b1;
            pick = $urandom_range(0, 99);
            if (live_blocks.size() > 0 && (pick < 40 || live_blocks.size() > 60)) begin
                free_live($urandom_range(0, live_blocks.size() - 1));
            end else if (pick < 43) begin
                send_item(OP_RELEASE, '0, '0);
            end else if (pick < 46) begin
                req = (pick == 43) ? '0 : REQ_W'($urandom_range(MAX_REQ + 1, (1 << REQ_W) - 1));
                send_item(OP_ALLOC, req, '0);
            end else if (pick < 49) begin
                send_item(OP_ALLOC, REQ_W'($urandom_range(1, MAX_REQ)), '0);
            end else if (pick < 50) begin
                send_item(OP_UNUSED, REQ_W'($urandom), ADDR_W'($urandom));
            end else begin
                send_item(OP_ALLOC, REQ_W'($urandom_range(1, 700)), '0);
            end
        end
    endtask

    task automatic test_reinit();
        send_item(OP_INIT, '0, '0);
        send_item(OP_ALLOC, REQ_W'(64), '0);
    endtask

    // main sequence
    initial begin
        int unsigned drain;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_opcode         = OP_ALLOC;
        s_request_bytes  = '0;
        s_payload_offset = '0;
        error_count      = 0;
        gaps_on          = 1'b1;
        hold_sink        = 1'b0;
        heap_fresh();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(600, 1'b1);
        test_reinit();
        test_random(600, 1'b0);
        s_valid <= 1'b0;

        // drain, then a short quiet tail
        drain = 0;
        while (grant_q.size() != 0 && drain < 200000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (100) @(posedge aclk);
        if (error_count == 0 && grant_q.size() == 0) begin
            $display("boundary_tag_heap_allocator verification clean");
        end else begin
            $display("boundary_tag_heap_allocator verification failed");
        end
        $finish;
    end

endmodule
